### design/face_fraction_from_corner_levelset_core_defines.svh
// Assertion macros shared by the face fraction core modules.
`ifndef FACE_FRACTION_FROM_CORNER_LEVELSET_CORE_DEFINES_SVH
`define FACE_FRACTION_FROM_CORNER_LEVELSET_CORE_DEFINES_SVH

// Condition must never hold outside reset.
`define FFCL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ffcl: forbidden condition seen");

// Antecedent implies consequent on the next cycle.
`define FFCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffcl: next-cycle check failed");

`endif

### design/ffcl_pkg.sv
// Package for the face fraction core: widths, share modes and item types.
package ffcl_pkg;

	localparam int PHI_W        = 24;
	localparam int VAL_W        = PHI_W + 2;
	localparam int OP_W         = VAL_W + 1;
	localparam int PROD_W       = 2 * OP_W;
	localparam int OUT_FRAC     = 16;
	localparam int SHARE_W      = OUT_FRAC + 1;
	localparam int THRESH_W     = 17;
	localparam int N_TRI        = 4;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd58982;
	localparam logic [SHARE_W-1:0]  SHARE_ONE    = 17'd65536;

	// How a triangle's covered share is built from its quotient
	typedef enum logic [1:0] {
		SH_ONE,
		SH_INV,
		SH_DIRECT,
		SH_NONE
	} share_mode_t;

	typedef struct packed {
		share_mode_t        mode;
		logic [PROD_W-1:0]  num;
		logic [PROD_W-1:0]  den;
	} tri_op_t;

	typedef tri_op_t [N_TRI-1:0] face_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### design/ffcl_front.sv
// Front end: accepts corner values, classifies the four triangles, forms products.
module ffcl_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [ffcl_pkg::PHI_W-1:0] phi_a,
	input  logic signed [ffcl_pkg::PHI_W-1:0] phi_b,
	input  logic signed [ffcl_pkg::PHI_W-1:0] phi_c,
	input  logic signed [ffcl_pkg::PHI_W-1:0] phi_d,
	input  ffcl_pkg::q_stat_t             q_stat,
	output logic                          stall,
	output logic                          q_push,
	output ffcl_pkg::face_item_t          q_item
);

	localparam int VW = ffcl_pkg::VAL_W;
	localparam int OW = ffcl_pkg::OP_W;

	typedef struct packed {
		ffcl_pkg::share_mode_t mode;
		logic [OW-1:0]         sq;
		logic [OW-1:0]         d1;
		logic [OW-1:0]         d2;
	} tri_pre_t;

	// Sort three values and pick the operands of the covered share
	function automatic tri_pre_t classify(input logic signed [VW-1:0] p,
			input logic signed [VW-1:0] q, input logic signed [VW-1:0] r);
		logic signed [VW-1:0] lo, md, hi, t;
		logic signed [OW-1:0] lo_x, md_x, hi_x;
		tri_pre_t res;
		lo = p;
		md = q;
		hi = r;
		if (lo > md) begin
			t = lo; lo = md; md = t;
		end
		if (md > hi) begin
			t = md; md = hi; hi = t;
		end
		if (lo > md) begin
			t = lo; lo = md; md = t;
		end
		lo_x = OW'(lo);
		md_x = OW'(md);
		hi_x = OW'(hi);
		res = '0;
		if (hi <= 0) begin
			res.mode = ffcl_pkg::SH_ONE;
		end else if (md <= 0) begin
			res.mode = ffcl_pkg::SH_INV;
			res.sq   = hi_x;
			res.d1   = hi_x - lo_x;
			res.d2   = hi_x - md_x;
		end else if (lo <= 0) begin
			res.mode = ffcl_pkg::SH_DIRECT;
			res.sq   = -lo_x;
			res.d1   = md_x - lo_x;
			res.d2   = hi_x - lo_x;
		end else begin
			res.mode = ffcl_pkg::SH_NONE;
		end
		return res;
	endfunction

	logic                 adv;
	logic signed [VW-1:0] c0, c1, c2, c3, ctr;
	tri_pre_t             pre_s1 [ffcl_pkg::N_TRI];
	logic                 v_s1;
	ffcl_pkg::face_item_t item_s2;
	logic                 v_s2;

	// Whole front moves unless the queue cannot take the item in stage two
	assign adv    = !(v_s2 && q_stat.full);
	assign stall  = !adv;
	assign q_push = v_s2 && adv;
	assign q_item = item_s2;

	// Corners scaled by four; centre is then the plain sum
	assign c0  = {phi_a, 2'b00};
	assign c1  = {phi_b, 2'b00};
	assign c2  = {phi_c, 2'b00};
	assign c3  = {phi_d, 2'b00};
	assign ctr = VW'(phi_a) + VW'(phi_b) + VW'(phi_c) + VW'(phi_d);

	// Stage one: classification
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			pre_s1[0] <= classify(ctr, c0, c1);
			pre_s1[1] <= classify(ctr, c1, c3);
			pre_s1[2] <= classify(ctr, c3, c2);
			pre_s1[3] <= classify(ctr, c2, c0);
		end
	end

	// Stage two: numerator and denominator products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			for (int i = 0; i < ffcl_pkg::N_TRI; i++) begin
				item_s2[i].mode <= pre_s1[i].mode;
				item_s2[i].num  <= pre_s1[i].sq * pre_s1[i].sq;
				item_s2[i].den  <= pre_s1[i].d1 * pre_s1[i].d2;
			end
		end
	end

endmodule

### design/ffcl_queue.sv
// Short queue of classified items between front and back.
`include "face_fraction_from_corner_levelset_core_defines.svh"
module ffcl_queue #(
	parameter int DEPTH = ffcl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ffcl_pkg::face_item_t push_item,
	input  logic                 pop,
	output ffcl_pkg::face_item_t head_item,
	output ffcl_pkg::q_stat_t    stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ffcl_pkg::face_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head_item  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`FFCL_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && stat.full)
	`FFCL_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && stat.empty)
	`FFCL_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, cnt_q == CNT_W'($past(cnt_q) + 1'b1))

endmodule

### design/ffcl_back.sv
// Back end: pipelined restoring dividers, share averaging, snap and output register.
`include "face_fraction_from_corner_levelset_core_defines.svh"
module ffcl_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ffcl_pkg::face_item_t            head_item,
	input  ffcl_pkg::q_stat_t               q_stat,
	output logic                            q_pop,
	input  logic [ffcl_pkg::THRESH_W-1:0]   snap_thr,
	input  logic                            out_pop,
	output logic                            out_empty,
	output logic [ffcl_pkg::SHARE_W-1:0]    out_frac
);

	localparam int NT    = ffcl_pkg::N_TRI;
	localparam int PW    = ffcl_pkg::PROD_W;
	localparam int RW    = PW + 1;
	localparam int SW    = ffcl_pkg::SHARE_W;
	localparam int STEPS = ffcl_pkg::OUT_FRAC + 1;
	localparam int SUM_W = SW + 2;
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(4 * 65536);

	logic                  en;
	logic                  v_q   [STEPS+1];
	logic [RW-1:0]         rem_q [STEPS+1][NT];
	logic [PW-1:0]         den_q [STEPS+1][NT];
	logic [SW-1:0]         quo_q [STEPS+1][NT];
	ffcl_pkg::share_mode_t mode_q [STEPS+1][NT];
	logic [SW-1:0]         share [NT];
	logic [SUM_W-1:0]      share_sum;
	logic [SW-1:0]         avg;
	logic                  out_v_q;
	logic [SW-1:0]         out_frac_q;

	// Everything advances while the output register is free or being taken
	assign en        = !out_v_q || out_pop;
	assign q_pop     = en && !q_stat.empty;
	assign out_empty = !out_v_q;
	assign out_frac  = out_frac_q;

	// Valid bits of the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= STEPS; s++) begin
				v_q[s] <= 1'b0;
			end
		end else if (en) begin
			v_q[0] <= q_pop;
			for (int s = 1; s <= STEPS; s++) begin
				v_q[s] <= v_q[s-1];
			end
		end
	end

	// Stage zero: load from the queue head
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NT; i++) begin
				rem_q[0][i]  <= {1'b0, head_item[i].num};
				den_q[0][i]  <= head_item[i].den;
				quo_q[0][i]  <= '0;
				mode_q[0][i] <= head_item[i].mode;
			end
		end
	end

	// One quotient bit per stage and lane
	for (genvar s = 1; s <= STEPS; s++) begin : g_step
		for (genvar i = 0; i < NT; i++) begin : g_lane
			logic [RW-1:0] sh;
			logic          ge;
			assign sh = (s == 1) ? rem_q[s-1][i] : {rem_q[s-1][i][RW-2:0], 1'b0};
			assign ge = (sh >= {1'b0, den_q[s-1][i]});
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[s][i]  <= ge ? sh - {1'b0, den_q[s-1][i]} : sh;
					den_q[s][i]  <= den_q[s-1][i];
					quo_q[s][i]  <= {quo_q[s-1][i][SW-2:0], ge};
					mode_q[s][i] <= mode_q[s-1][i];
				end
			end
		end
	end

	// Per-triangle share from quotient and mode
	always_comb begin
		for (int i = 0; i < NT; i++) begin
			case (mode_q[STEPS][i])
				ffcl_pkg::SH_ONE:    share[i] = ffcl_pkg::SHARE_ONE;
				ffcl_pkg::SH_INV:    share[i] = ffcl_pkg::SHARE_ONE - quo_q[STEPS][i];
				ffcl_pkg::SH_DIRECT: share[i] = quo_q[STEPS][i];
				default:             share[i] = '0;
			endcase
		end
	end

	// Average and snap
	assign share_sum = SUM_W'(share[0]) + SUM_W'(share[1]) + SUM_W'(share[2])
		+ SUM_W'(share[3]);
	assign avg = share_sum[SUM_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_q[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_q[STEPS]) begin
			out_frac_q <= (avg > snap_thr) ? ffcl_pkg::SHARE_ONE : avg;
		end
	end

	`FFCL_ASSERT_NEVER(a_sum_range, clk, arst_n, v_q[STEPS] && (share_sum > SUM_MAX))
	`FFCL_ASSERT_NEVER(a_out_range, clk, arst_n, out_v_q && (out_frac_q > ffcl_pkg::SHARE_ONE))
	`FFCL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_v_q && !out_pop, out_v_q && $stable(out_frac_q))

endmodule

### design/face_fraction_from_corner_levelset_core.sv
// Top level of the face covered-fraction core.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | push / full            | corner_phi_a..corner_phi_d (s24)
//  result   | pop / empty            | covered_fraction (u17, Q1.16)
//  config   | cfg_valid / cfg_ready  | snap_threshold (u17, Q1.16)
//
// One item per cycle sustained while results are popped; each item passes the
// first and second front stages, the queue, the divider load stage, seventeen
// divider stages and the output register.
// The seventeen-step restoring divider per triangle sets the depth.
// Reset (arst_n low) empties the pipeline and queue and loads the reset threshold.
// A held result stalls the back end; the queue then fills and full rises.
module face_fraction_from_corner_levelset_core #(
	parameter int QUEUE_DEPTH = ffcl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [ffcl_pkg::PHI_W-1:0]    corner_phi_a,
	input  logic signed [ffcl_pkg::PHI_W-1:0]    corner_phi_b,
	input  logic signed [ffcl_pkg::PHI_W-1:0]    corner_phi_c,
	input  logic signed [ffcl_pkg::PHI_W-1:0]    corner_phi_d,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [ffcl_pkg::SHARE_W-1:0]         covered_fraction,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ffcl_pkg::THRESH_W-1:0]        snap_threshold
);

	logic [ffcl_pkg::THRESH_W-1:0] thr_q;
	ffcl_pkg::q_stat_t             q_stat;
	ffcl_pkg::face_item_t          push_item, head_item;
	logic                          q_push, q_pop, stall;

	// Threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ffcl_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= snap_threshold;
		end
	end

	assign full = stall;

	ffcl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(push && !stall),
		.phi_a   (corner_phi_a),
		.phi_b   (corner_phi_b),
		.phi_c   (corner_phi_c),
		.phi_d   (corner_phi_d),
		.q_stat  (q_stat),
		.stall   (stall),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	ffcl_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.pop      (q_pop),
		.head_item(head_item),
		.stat     (q_stat)
	);

	ffcl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_item(head_item),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.snap_thr (thr_q),
		.out_pop  (pop),
		.out_empty(empty),
		.out_frac (covered_fraction)
	);

endmodule

### tb/tb.sv
// Self-checking testbench for the face covered-fraction core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WDOG_LIMIT = 2000;
	localparam int DRAIN_WAIT = 30;
	localparam int N_RAND     = 100;
	localparam int PW         = ffcl_pkg::PHI_W;
	localparam int TW         = ffcl_pkg::THRESH_W;
	localparam int SW         = ffcl_pkg::SHARE_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic full, empty, cfg_ready;
	logic signed [PW-1:0] corner_phi_a = '0, corner_phi_b = '0;
	logic signed [PW-1:0] corner_phi_c = '0, corner_phi_d = '0;
	logic [TW-1:0] snap_threshold = '0;
	logic [SW-1:0] covered_fraction;

	logic [TW-1:0] thr_model;
	logic [SW-1:0] fraction_q[$];
	int mismatches = 0;
	int n_sent = 0, n_got = 0, wdog = 0;
	int pop_idle = 0;
	bit pop_calm = 1'b0;

	face_fraction_from_corner_levelset_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.corner_phi_a(corner_phi_a), .corner_phi_b(corner_phi_b),
		.corner_phi_c(corner_phi_c), .corner_phi_d(corner_phi_d),
		.empty(empty), .pop(pop), .covered_fraction(covered_fraction),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.snap_threshold(snap_threshold)
	);

	always #6 clk = ~clk;

	// floor(num * 2^16 / den), restoring division
	function automatic logic [SW-1:0] quot_q16(longint unsigned num,
			longint unsigned den);
		logic [SW-1:0] q;
		longint unsigned r;
		q = '0;
		r = num;
		if (den == 0) return '0;
		if (r >= den) begin
			q[0] = 1'b1;
			r -= den;
		end
		for (int i = 0; i < ffcl_pkg::OUT_FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r -= den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// covered share of one triangle
	function automatic logic [SW-1:0] tri_cover(longint p, longint q, longint r);
		longint t;
		if (p > q) begin t = p; p = q; q = t; end
		if (q > r) begin t = q; q = r; r = t; end
		if (p > q) begin t = p; p = q; q = t; end
		if (r <= 0) return ffcl_pkg::SHARE_ONE;
		if (q <= 0)
			return ffcl_pkg::SHARE_ONE
				- quot_q16(longint'(r * r), longint'((r - p) * (r - q)));
		if (p <= 0)
			return quot_q16(longint'(p * p), longint'((q - p) * (r - p)));
		return '0;
	endfunction

	// expected covered fraction of a face under the given threshold
	function automatic logic [SW-1:0] face_cover(logic signed [PW-1:0] a,
			logic signed [PW-1:0] b, logic signed [PW-1:0] c,
			logic signed [PW-1:0] d, logic [TW-1:0] thr);
		longint c0, c1, c2, c3, ctr;
		logic [19:0] sum;
		logic [SW-1:0] avg;
		c0 = 4 * longint'(a);
		c1 = 4 * longint'(b);
		c2 = 4 * longint'(c);
		c3 = 4 * longint'(d);
		ctr = (c0 + c1 + c2 + c3) / 4;
		sum = 20'(tri_cover(ctr, c0, c1)) + 20'(tri_cover(ctr, c1, c3))
			+ 20'(tri_cover(ctr, c3, c2)) + 20'(tri_cover(ctr, c2, c0));
		avg = sum[18:2];
		if (avg > thr) avg = ffcl_pkg::SHARE_ONE;
		return avg;
	endfunction

	// send one face; optional idle burst afterwards
	task automatic send_face(logic signed [PW-1:0] a, logic signed [PW-1:0] b,
			logic signed [PW-1:0] c, logic signed [PW-1:0] d,
			int want, bit allow_idle);
		corner_phi_a <= a;
		corner_phi_b <= b;
		corner_phi_c <= c;
		corner_phi_d <= d;
		push <= 1'b1;
		do @(posedge clk); while (full);
		if (want >= 0 && want != int'(face_cover(a, b, c, d, thr_model)))
			$display("tb: note: table row %0d disagrees with predictor", n_sent);
		fraction_q.push_back(want >= 0 ? SW'(want) : face_cover(a, b, c, d, thr_model));
		n_sent++;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// write the threshold once the pipeline is empty
	task automatic set_threshold(logic [TW-1:0] v);
		push <= 1'b0;
		while (fraction_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		snap_threshold <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thr_model = v;
	endtask

	// random corner value: mostly near the interface, sometimes full range
	function automatic logic signed [PW-1:0] rand_phi();
		case ($urandom_range(0, 3))
			0: return PW'($urandom);
			1: return PW'(int'($urandom_range(0, 2048)) - 1024);
			2: return PW'(int'($urandom_range(0, 262144)) - 131072);
			default: return PW'(int'($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	// result side: random pop idle bursts until pop_calm is set, compare against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			n_got++;
			if (fraction_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("tb: unexpected result %0d", covered_fraction);
			end else begin
				if (covered_fraction !== fraction_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: covered_fraction exp %0d got %0d",
							fraction_q[0], covered_fraction);
				end
				void'(fraction_q.pop_front());
			end
		end
		if (pop_calm) begin
			pop <= 1'b1;
		end else if (pop_idle > 0) begin
			pop <= 1'b0;
			pop_idle <= pop_idle - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			pop <= 1'b0;
			pop_idle <= int'($urandom_range(0, 6));
		end else begin
			pop <= 1'b1;
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("tb: watchdog expired");
			$display("tb: FAIL");
			$finish;
		end
	end

	typedef struct {
		int a, b, c, d, want;
	} face_row_t;

	face_row_t dir_rows[] = '{
		'{-1, -1, -1, -1, 65536},
		'{1, 1, 1, 1, 0},
		'{0, 0, 0, 0, 65536},
		'{-8388608, -8388608, -8388608, -8388608, 65536},
		'{8388607, 8388607, 8388607, 8388607, 0},
		'{-8388608, 8388607, 8388607, -8388608, -1},
		'{8388607, -8388608, -8388608, 8388607, -1},
		'{-8388608, 8388607, -8388608, 8388607, -1},
		'{-1, 1, 1, 1, -1},
		'{1, -1, -1, -1, -1},
		'{0, 1, 1, 1, -1},
		'{0, 0, 1, 1, -1},
		'{-65536, 65536, 65536, -65536, -1},
		'{-65536, -65536, 65536, 65536, -1},
		'{-100, 300, 300, 300, -1},
		'{-300, 100, -300, -300, -1},
		'{5, 5, -5, 5, -1},
		'{-8388608, 8388607, 0, 0, -1},
		'{1, 2, 3, -6, -1},
		'{0, 0, 0, 1, -1}
	};

	logic [TW-1:0] thr_list[] = '{17'd0, 17'd65536, 17'd131071, 17'd32768};

	initial begin
		thr_model = ffcl_pkg::THRESH_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset threshold, no idling, then random faces with idling
		foreach (dir_rows[i])
			send_face(PW'(dir_rows[i].a), PW'(dir_rows[i].b), PW'(dir_rows[i].c),
				PW'(dir_rows[i].d), dir_rows[i].want, 1'b0);
		for (int k = 0; k < N_RAND; k++)
			send_face(rand_phi(), rand_phi(), rand_phi(), rand_phi(), -1, 1'b1);

		// random faces under several thresholds, the last phase without idling
		foreach (thr_list[t]) begin
			set_threshold(t == 3 ? TW'($urandom_range(40000, 65535)) : thr_list[t]);
			if (t == 3) pop_calm = 1'b1;
			for (int k = 0; k < N_RAND; k++)
				send_face(rand_phi(), rand_phi(), rand_phi(), rand_phi(), -1, t != 3);
		end

		push <= 1'b0;
		while (fraction_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("tb: %0d faces sent, %0d fractions checked, five threshold settings",
			n_sent, n_got);
		if (mismatches == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
